// File: rtl/u8u16_pkg.sv
// package: shared types and constants of the utf-8 to utf-16 transcoder
package u8u16_pkg;

    localparam int BYTE_W    = 8;
    localparam int UNIT_W    = 16;
    localparam int COUNT_W   = 16;
    localparam int CAP_W     = 16;
    localparam int ACCUM_W   = 21;
    localparam int MAX_RES   = 3;

    // default result queue depth, power of two, at least 2 * MAX_RES
    localparam int FIFO_DEPTH_DEF = 8;

    localparam logic [CAP_W-1:0] CAP_RESET = 16'hFFFF;

    // lead byte masks and patterns
    localparam logic [BYTE_W-1:0] MASK_LEAD2 = 8'hE0;
    localparam logic [BYTE_W-1:0] PAT_LEAD2  = 8'hC0;
    localparam logic [BYTE_W-1:0] MASK_LEAD3 = 8'hF0;
    localparam logic [BYTE_W-1:0] PAT_LEAD3  = 8'hE0;
    localparam logic [BYTE_W-1:0] MASK_LEAD4 = 8'hF8;
    localparam logic [BYTE_W-1:0] PAT_LEAD4  = 8'hF0;
    localparam logic [BYTE_W-1:0] ASCII_LIM  = 8'h80;
    localparam logic [5:0]        CONT_MASK  = 6'h3F;

    localparam logic [ACCUM_W-1:0] SUPP_BASE = 21'h010000;
    localparam logic [UNIT_W-1:0]  HI_SURR   = 16'hD800;
    localparam logic [UNIT_W-1:0]  LO_SURR   = 16'hDC00;

    typedef enum logic [1:0] {
        SEQ_ONE   = 2'd0,
        SEQ_TWO   = 2'd1,
        SEQ_THREE = 2'd2,
        SEQ_FOUR  = 2'd3
    } t_seq_kind;

    typedef struct packed {
        logic [UNIT_W-1:0]  code_unit;
        logic               last;
        logic               is_end;
        logic [COUNT_W-1:0] unit_count;
        logic               end_written;
    } t_result;

endpackage

// File: rtl/utf8_to_utf16_decoder_top.sv
// top level: utf-8 byte stream to utf-16 code unit transcoder
// path: an accepted byte passes the input register, then its results enter the result queue
// throughput: one byte per cycle; each byte yields zero to three results that
// drain one per cycle unless the output stalls, from a small result queue, and
// input stalls only if the queue lacks room for three results per byte in flight
// reset: synchronous active low, clears sequence state, counters and queue
module utf8_to_utf16_decoder_top
    import u8u16_pkg::*;
#(
    parameter int P_FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input byte channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [BYTE_W-1:0]  i_in_byte,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [UNIT_W-1:0]  o_code_unit,
    output logic               o_last,
    output logic               o_is_end,
    output logic [COUNT_W-1:0] o_unit_count,
    output logic               o_end_written,
    // capacity register write
    input  logic               i_cfg_we,
    input  logic [CAP_W-1:0]   i_cfg_data
);

    localparam int PW = $clog2(P_FIFO_DEPTH);
    localparam int CW = $clog2(P_FIFO_DEPTH + 1);

    // capacity register
    logic [CAP_W-1:0] r_cap;

    // input register
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;

    // decoder state
    logic [1:0]         r_pending, n_pending;
    t_seq_kind          r_kind, n_kind;
    logic [ACCUM_W-1:0] r_accum, n_accum;
    logic [COUNT_W-1:0] r_written, n_written;
    logic               r_full, n_full;

    // result queue
    t_result         r_fifo [P_FIFO_DEPTH];
    logic [PW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]   r_count;

    // results of the byte in the input register
    t_result    res [MAX_RES];
    logic [1:0] n_res;

    logic pop;
    logic in_accept;

    assign in_accept = i_in_valid && !o_in_stall;
    assign pop       = o_out_valid && !i_out_stall;

    // room for the byte in the input register and one more, three results each
    always_comb begin
        logic [CW:0] need;
        need = {1'b0, r_count} + (r_in_valid ? (CW+1)'(MAX_RES) : '0)
             + (CW+1)'(MAX_RES);
        o_in_stall = need > (CW+1)'(P_FIFO_DEPTH);
    end

    // one pass of decode over the registered byte
    always_comb begin
        logic               do_emit;
        logic               do_end;
        logic [ACCUM_W-1:0] emit_val;
        t_seq_kind          emit_kind;
        logic [1:0]         pend_dec;
        logic [ACCUM_W-1:0] cont_bits;
        logic [ACCUM_W-1:0] supp;
        logic [CAP_W-1:0]   eff;
        logic               cap_hit;
        logic [UNIT_W-1:0]  u0, u1;
        logic [1:0]         n_units;
        logic [COUNT_W-1:0] count_after;

        n_pending = r_pending;
        n_kind    = r_kind;
        n_accum   = r_accum;
        n_written = r_written;
        n_full    = r_full;

        do_emit   = 1'b0;
        do_end    = 1'b0;
        emit_val  = r_accum;
        emit_kind = r_kind;
        pend_dec  = r_pending - 2'd1;
        supp      = '0;
        u0        = '0;
        u1        = '0;
        n_units   = 2'd0;

        // low six bits of a continuation, placed by how many are still due
        unique case (pend_dec)
            2'd0:    cont_bits = ACCUM_W'({r_in_byte[5:0] & CONT_MASK});
            2'd1:    cont_bits = ACCUM_W'({r_in_byte[5:0] & CONT_MASK, 6'd0});
            default: cont_bits = ACCUM_W'({r_in_byte[5:0] & CONT_MASK, 12'd0});
        endcase

        // a capacity of one behaves as two
        eff     = (r_cap == CAP_W'(1)) ? CAP_W'(2) : r_cap;
        cap_hit = (eff == '0) || ({1'b0, r_written} >= ({1'b0, eff} - 17'd2));

        if (r_in_valid) begin
            if (r_in_byte == '0) begin
                // terminator flushes a cut-off sequence first
                do_emit = (r_pending != 2'd0);
                do_end  = 1'b1;
            end else if (r_pending != 2'd0) begin
                emit_val = r_accum | cont_bits;
                if (pend_dec == 2'd0) begin
                    do_emit = 1'b1;
                end else begin
                    n_pending = pend_dec;
                    n_accum   = emit_val;
                end
            end else begin
                n_full = r_full || cap_hit;
                if (!n_full) begin
                    priority if (r_in_byte < ASCII_LIM) begin
                        do_emit   = 1'b1;
                        emit_val  = ACCUM_W'(r_in_byte);
                        emit_kind = SEQ_ONE;
                    end else if ((r_in_byte & MASK_LEAD2) == PAT_LEAD2) begin
                        n_kind    = SEQ_TWO;
                        n_pending = 2'd1;
                        n_accum   = ACCUM_W'({r_in_byte[4:0], 6'd0});
                    end else if ((r_in_byte & MASK_LEAD3) == PAT_LEAD3) begin
                        n_kind    = SEQ_THREE;
                        n_pending = 2'd2;
                        n_accum   = ACCUM_W'({r_in_byte[3:0], 12'd0});
                    end else if ((r_in_byte & MASK_LEAD4) == PAT_LEAD4) begin
                        n_kind    = SEQ_FOUR;
                        n_pending = 2'd3;
                        n_accum   = ACCUM_W'({r_in_byte[2:0], 18'd0});
                    end else begin
                        // stray continuation or invalid lead, skipped
                        n_pending = r_pending;
                    end
                end
            end
        end

        if (do_emit) begin
            if (emit_kind == SEQ_FOUR && emit_val >= SUPP_BASE) begin
                supp    = emit_val - SUPP_BASE;
                u0      = HI_SURR + UNIT_W'(supp[ACCUM_W-1:10]);
                u1      = LO_SURR + UNIT_W'(supp[9:0]);
                n_units = 2'd2;
            end else begin
                u0      = emit_val[UNIT_W-1:0];
                n_units = 2'd1;
            end
            n_pending = 2'd0;
            n_kind    = SEQ_ONE;
            n_accum   = '0;
        end

        count_after = r_written + COUNT_W'(n_units);
        n_written   = count_after;

        for (int k = 0; k < MAX_RES; k++) begin
            res[k] = '0;
        end
        res[0].code_unit = u0;
        res[1].code_unit = u1;
        n_res = n_units;

        if (do_end) begin
            res[n_units].code_unit   = '0;
            res[n_units].is_end      = 1'b1;
            res[n_units].unit_count  = count_after;
            res[n_units].end_written = (r_cap != '0);
            n_res     = n_units + 2'd1;
            n_pending = 2'd0;
            n_kind    = SEQ_ONE;
            n_accum   = '0;
            n_written = '0;
            n_full    = 1'b0;
        end

        // final result of this byte carries last
        if (n_res != 2'd0) begin
            res[n_res - 2'd1].last = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap      <= CAP_RESET;
            r_in_valid <= 1'b0;
            r_pending  <= 2'd0;
            r_kind     <= SEQ_ONE;
            r_accum    <= '0;
            r_written  <= '0;
            r_full     <= 1'b0;
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_count    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            r_in_valid <= in_accept;
            r_pending  <= n_pending;
            r_kind     <= n_kind;
            r_accum    <= n_accum;
            r_written  <= n_written;
            r_full     <= n_full;
            r_wr_ptr   <= r_wr_ptr + PW'(n_res);
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            r_count <= r_count + CW'(n_res) - CW'(pop);
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_in_byte;
        end
        for (int k = 0; k < MAX_RES; k++) begin
            if (2'(k) < n_res) begin
                r_fifo[r_wr_ptr + PW'(k)] <= res[k];
            end
        end
    end

    // queue head drives the result channel
    assign o_out_valid   = (r_count != '0);
    assign o_code_unit   = r_fifo[r_rd_ptr].code_unit;
    assign o_last        = r_fifo[r_rd_ptr].last;
    assign o_is_end      = r_fifo[r_rd_ptr].is_end;
    assign o_unit_count  = r_fifo[r_rd_ptr].unit_count;
    assign o_end_written = r_fifo[r_rd_ptr].end_written;

endmodule

// File: rtl/u8u16_checker.sv
// checker: port level assertions for the transcoder, bound to the top level
module u8u16_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [15:0] o_code_unit,
    input logic        o_last,
    input logic        o_is_end,
    input logic [15:0] o_unit_count,
    input logic        o_end_written
);

    // queue empties on reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_code_unit)
            && $stable(o_last) && $stable(o_is_end) && $stable(o_unit_count)
            && $stable(o_end_written))
        else $error("stalled result changed");

    // end report closes the results of its byte and carries no unit
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_end |-> o_last && (o_code_unit == 16'd0))
        else $error("end report malformed");

    // unit results carry no count and no end flag
    a_unit_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_is_end |-> (o_unit_count == 16'd0) && !o_end_written)
        else $error("unit result has end fields");

endmodule

bind utf8_to_utf16_decoder_top u8u16_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_code_unit   (o_code_unit),
    .o_last        (o_last),
    .o_is_end      (o_is_end),
    .o_unit_count  (o_unit_count),
    .o_end_written (o_end_written)
);

// File: tb/tb_utf8_to_utf16_decoder_top.sv
// testbench: utf-8 to utf-16 transcoder, byte stream in, predicted code units checked out
`timescale 1ns / 100ps

module tb_utf8_to_utf16_decoder_top;
    import u8u16_pkg::*;

    localparam int N_PHASE      = 10;
    localparam int PHASE_BYTES  = 32;   // random bytes per phase, roughly
    localparam int DRAIN_CYCLES = 8;    // covers the input register and result queue with margin
    localparam int MAX_PRINT    = 40;   // keeps a broken run readable

    // clock, reset and dut ports
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               o_in_stall;
    logic [BYTE_W-1:0]  in_byte = '0;
    logic               o_out_valid;
    logic               out_stall = 1'b0;
    logic [UNIT_W-1:0]  o_code_unit;
    logic               o_last;
    logic               o_is_end;
    logic [COUNT_W-1:0] o_unit_count;
    logic               o_end_written;
    logic               cfg_we = 1'b0;
    logic [CAP_W-1:0]   cfg_data = '0;

    // byte stream waiting to be sent, and code units still owed by the dut
    logic [BYTE_W-1:0]  byte_q [$];
    t_result            unit_q [$];

    // idling of each side, in percent of cycles
    int                 send_idle_pct = 0;
    int                 recv_stall_pct = 0;

    // run statistics
    int                 n_err = 0;
    int                 n_bytes = 0;
    int                 n_checked = 0;
    int                 n_pairs = 0;
    int                 n_strings = 0;

    // transcoder state as the testbench sees it
    logic [CAP_W-1:0]   cap_reg = CAP_RESET;
    logic [1:0]         pend_cnt = '0;
    t_seq_kind          seq_kind_q = SEQ_ONE;
    logic [ACCUM_W-1:0] accum = '0;
    logic [COUNT_W-1:0] n_written = '0;
    logic               full_flag = 1'b0;

    // results of the byte being predicted
    t_result            step_res [MAX_RES];
    int                 step_n;

    utf8_to_utf16_decoder_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_byte     (in_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (out_stall),
        .o_code_unit   (o_code_unit),
        .o_last        (o_last),
        .o_is_end      (o_is_end),
        .o_unit_count  (o_unit_count),
        .o_end_written (o_end_written),
        .i_cfg_we      (cfg_we),
        .i_cfg_data    (cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // one code unit written to the destination buffer
    task automatic put_unit(input logic [UNIT_W-1:0] u);
        t_result r;
        r = '0;
        r.code_unit = u;
        step_res[step_n] = r;
        step_n++;
        n_written = n_written + 1'b1;
    endtask

    // finished value: a supplementary value from a 4-byte lead becomes a surrogate pair
    task automatic emit_code_point();
        logic [ACCUM_W-1:0] v;
        v = accum;
        if (seq_kind_q == SEQ_FOUR && v >= SUPP_BASE) begin
            v = v - SUPP_BASE;
            put_unit(HI_SURR + {5'd0, v[20:10]});
            put_unit(LO_SURR + {6'd0, v[9:0]});
            n_pairs++;
        end else begin
            put_unit(v[UNIT_W-1:0]);
        end
        pend_cnt = '0;
        seq_kind_q = SEQ_ONE;
        accum = '0;
    endtask

    // expected code units for one accepted byte, appended to unit_q
    task automatic decode_byte(input logic [BYTE_W-1:0] b);
        t_result r;
        int eff;
        step_n = 0;
        if (b == '0) begin
            // terminator: flush a cut-off sequence with missing bits zero, then report the end
            if (pend_cnt != 0)
                emit_code_point();
            r = '0;
            r.is_end = 1'b1;
            r.unit_count = n_written;
            r.end_written = (cap_reg != '0);
            step_res[step_n] = r;
            step_n++;
            pend_cnt = '0;
            seq_kind_q = SEQ_ONE;
            accum = '0;
            n_written = '0;
            full_flag = 1'b0;
            n_strings++;
        end else if (pend_cnt != 0) begin
            // continuation: value is never checked, only the low six bits count
            pend_cnt = pend_cnt - 1'b1;
            accum = accum | ({15'd0, b[5:0]} << (6 * pend_cnt));
            if (pend_cnt == 0)
                emit_code_point();
        end else begin
            // lead byte: capacity is checked here only, capacity one acts as two
            eff = (cap_reg == 1) ? 2 : int'(cap_reg);
            if (!full_flag && (eff == 0 || int'(n_written) >= eff - 2))
                full_flag = 1'b1;
            if (!full_flag) begin
                if (b < ASCII_LIM) begin
                    seq_kind_q = SEQ_ONE;
                    accum = {13'd0, b};
                    emit_code_point();
                end else if ((b & MASK_LEAD2) == PAT_LEAD2) begin
                    seq_kind_q = SEQ_TWO;
                    pend_cnt = 2'd1;
                    accum = {10'd0, b[4:0], 6'd0};
                end else if ((b & MASK_LEAD3) == PAT_LEAD3) begin
                    seq_kind_q = SEQ_THREE;
                    pend_cnt = 2'd2;
                    accum = {5'd0, b[3:0], 12'd0};
                end else if ((b & MASK_LEAD4) == PAT_LEAD4) begin
                    seq_kind_q = SEQ_FOUR;
                    pend_cnt = 2'd3;
                    accum = {b[2:0], 18'd0};
                end
                // stray continuation or 0xf8 and up: skipped without a result
            end
        end
        for (int i = 0; i < step_n; i++) begin
            r = step_res[i];
            r.last = (i == step_n - 1);
            unit_q.push_back(r);
        end
    endtask

    task automatic check_field(input string nm, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            n_err++;
            if (n_err <= MAX_PRINT)
                $display("%0t: %s mismatch, expected %h actual %h", $time, nm, want, got);
        end
    endtask

    // one random character; mostly well formed, some noise and broken sequences
    task automatic gen_char();
        int pick;
        int n_cont;
        pick = $urandom_range(99);
        if (pick < 28) begin
            byte_q.push_back(8'($urandom_range(1, 127)));
        end else if (pick < 48) begin
            byte_q.push_back(8'hC0 | 8'($urandom_range(31)));
            byte_q.push_back(8'h80 | 8'($urandom_range(63)));
        end else if (pick < 63) begin
            byte_q.push_back(8'hE0 | 8'($urandom_range(15)));
            repeat (2) byte_q.push_back(8'h80 | 8'($urandom_range(63)));
        end else if (pick < 80) begin
            byte_q.push_back(8'hF0 | 8'($urandom_range(7)));
            repeat (3) byte_q.push_back(8'h80 | 8'($urandom_range(63)));
        end else if (pick < 90) begin
            // noise: any nonzero byte
            byte_q.push_back(8'($urandom_range(1, 255)));
        end else begin
            // broken: lead byte followed by too few continuations
            n_cont = $urandom_range(2, 4);
            byte_q.push_back(n_cont == 2 ? (8'hC0 | 8'($urandom_range(31))) :
                             n_cont == 3 ? (8'hE0 | 8'($urandom_range(15))) :
                                           (8'hF0 | 8'($urandom_range(7))));
            repeat ($urandom_range(0, n_cont - 2))
                byte_q.push_back(8'h80 | 8'($urandom_range(63)));
        end
    endtask

    // nothing in flight: queue empty, no byte offered, no unit owed, pipeline flushed
    task automatic wait_drained();
        do @(negedge i_clk);
        while (byte_q.size() != 0 || in_valid || unit_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // byte driver: offers the head of byte_q, predicts each byte as it is taken
    always @(posedge i_clk) begin : byte_driver
        logic fire;
        fire = in_valid && !o_in_stall;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (fire) begin
                decode_byte(in_byte);
                n_bytes++;
            end
            // a stalled byte holds; a new one goes out only after the last was taken
            if (!in_valid || fire) begin
                if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_valid <= 1'b1;
                    in_byte <= byte_q.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // unit monitor: every accepted result against the oldest expected unit
    always @(posedge i_clk) begin : unit_monitor
        t_result want;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) begin
                if (unit_q.size() == 0) begin
                    n_err++;
                    if (n_err <= MAX_PRINT)
                        $display("%0t: unexpected result, expected none actual unit %h end %b",
                                 $time, o_code_unit, o_is_end);
                end else begin
                    want = unit_q.pop_front();
                    check_field("code_unit", 32'(want.code_unit), 32'(o_code_unit));
                    check_field("last", 32'(want.last), 32'(o_last));
                    check_field("is_end", 32'(want.is_end), 32'(o_is_end));
                    check_field("unit_count", 32'(want.unit_count), 32'(o_unit_count));
                    check_field("end_written", 32'(want.end_written), 32'(o_end_written));
                    n_checked++;
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // run control: reset, then phases of capacity and idling, each drained before the next
    initial begin : run_ctrl
        logic [CAP_W-1:0] cap_val;
        int phase_start;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int ph = 0; ph < N_PHASE; ph++) begin
            wait_drained();
            // capacity written only while idle; phase zero runs on the reset value
            if (ph != 0) begin
                case (ph)
                    1: cap_val = 16'hFFFF;
                    2: cap_val = 16'd0;
                    3: cap_val = 16'd1;
                    4: cap_val = 16'd2;
                    5: cap_val = 16'd3;
                    6: cap_val = 16'd7;
                    7: cap_val = 16'($urandom_range(4, 40));
                    8: cap_val = 16'hFFFE;
                    default: cap_val = 16'($urandom_range(65535));
                endcase
                cfg_we <= 1'b1;
                cfg_data <= cap_val;
                @(posedge i_clk);
                cfg_we <= 1'b0;
                cap_reg = cap_val;
            end
            @(negedge i_clk);
            // cycle through no idling, sender idle, receiver stall, both
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            if (ph == 0) begin
                // ascii, up to the largest value
                byte_q = {8'h41, 8'h7F, 8'h00};
                // 2-byte and 3-byte sequences
                byte_q = {byte_q, 8'hC2, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'h00};
                // surrogate pair and the largest 21-bit value
                byte_q = {byte_q, 8'hF0, 8'h9F, 8'h98, 8'h80, 8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'h00};
                // stray bytes, a continuation of any value, a 4-byte cut off by the end
                byte_q = {byte_q, 8'h80, 8'hF8, 8'hFF, 8'hC3, 8'h41, 8'hF0, 8'h90, 8'h00};
                // empty string
                byte_q.push_back(8'h00);
            end else begin
                phase_start = byte_q.size();
                while (byte_q.size() - phase_start < PHASE_BYTES) begin
                    repeat ($urandom_range(0, 10)) gen_char();
                    byte_q.push_back(8'h00);
                end
            end
        end
        wait_drained();
        $display("covered %0d bytes in %0d strings over %0d capacity settings", n_bytes,
                 n_strings, N_PHASE);
        $display("checked %0d code units and end reports, %0d surrogate pairs", n_checked,
                 n_pairs);
        if (n_err == 0) begin
            $display("tb_utf8_to_utf16_decoder_top passed");
        end else begin
            $display("tb_utf8_to_utf16_decoder_top failed");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin : watchdog
        #400000;
        $display("tb_utf8_to_utf16_decoder_top failed");
        $finish;
    end

endmodule
